### sv/scnr_pkg.sv
// Package for the satellite carrier-to-noise converter.
// Holds widths, Horner coefficients and the stage records shared by the cells.
// No dependencies.
package scnr_pkg;

  localparam int RAW_W  = 16;
  localparam int OUT_W  = 20;
  localparam int RAD_W  = 36;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int FRAC_W = 16;
  localparam int Y_W    = 38;
  localparam int P_W    = ROOT_W + 1 + Y_W;
  localparam int HRN_N  = 5;

  localparam logic [RAW_W-1:0] CN_OFFSET = RAW_W'(3000);
  localparam logic [OUT_W-1:0] OUT_MAX   = '1;
  localparam logic [OUT_W-1:0] CNR_TOP   = OUT_W'(588570);

  localparam logic signed [Y_W-1:0] HRN_Y0 = Y_W'(64'sd16346 * 64'sd65536);

  localparam logic signed [Y_W-1:0] HRN_K [HRN_N] = '{
    Y_W'(-(64'sd143410 * 64'sd65536)),
    Y_W'(64'sd502590 * 64'sd65536),
    Y_W'(-(64'sd889770 * 64'sd65536)),
    Y_W'(64'sd895650 * 64'sd65536),
    Y_W'(64'sd588570 * 64'sd65536)
  };

  localparam logic HRN_NEG [HRN_N] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

  typedef struct packed {
    logic             valid;
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_stage_t;

  typedef struct packed {
    logic                    valid;
    logic [ROOT_W-1:0]       x;
    logic signed [Y_W-1:0]   y;
  } hrn_stage_t;

endpackage

### sv/scnr_if.sv
// Channel interfaces for the carrier-to-noise converter.
// Valid/ready transfer with payload; depends on scnr_pkg.
interface scnr_in_if;
  import scnr_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_cn;
  modport source (output valid, output raw_cn, input ready);
  modport sink (input valid, input raw_cn, output ready);
endinterface

interface scnr_out_if;
  import scnr_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] cnr_millidb;
  modport source (output valid, output cnr_millidb, input ready);
  modport sink (input valid, input cnr_millidb, output ready);
endinterface

### sv/scnr_sqrt_cell.sv
// One digit of the integer square root: shift in two radicand bits,
// trial-subtract, append a root bit. Depends on scnr_pkg.
module scnr_sqrt_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  scnr_pkg::sqrt_stage_t d,
  output scnr_pkg::sqrt_stage_t q
);
  import scnr_pkg::*;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             ge;
  sqrt_stage_t      nxt;

  always_comb begin
    rem_sh    = {d.rem, d.rad[RAD_W-1 -: 2]};
    trial     = {{(REM_W-ROOT_W){1'b0}}, d.root, 2'b01};
    ge        = rem_sh >= trial;
    nxt.valid = d.valid;
    nxt.rad   = {d.rad[RAD_W-3:0], 2'b00};
    nxt.rem   = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    nxt.root  = {d.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.rad  <= nxt.rad;
      q.rem  <= nxt.rem;
      q.root <= nxt.root;
    end
  end

endmodule

### sv/scnr_horner_cell.sv
// One Horner step in Q16: y' = floor(x*y / 2^16) + K, or K minus that term.
// Multiply stage, then add stage. Depends on scnr_pkg.
module scnr_horner_cell #(
  parameter logic signed [scnr_pkg::Y_W-1:0] K   = '0,
  parameter logic                            NEG = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  scnr_pkg::hrn_stage_t d,
  output scnr_pkg::hrn_stage_t q
);
  import scnr_pkg::*;

  logic                  m_valid_r;
  logic [ROOT_W-1:0]     m_x_r;
  logic signed [P_W-1:0] m_prod_r;
  logic signed [P_W-1:0] prod_nxt;
  logic signed [Y_W-1:0] term;
  logic signed [Y_W-1:0] y_nxt;

  always_comb begin
    prod_nxt = P_W'($signed({1'b0, d.x}) * d.y);
    term     = Y_W'(m_prod_r >>> FRAC_W);
    y_nxt    = NEG ? K - term : term + K;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      q.valid   <= 1'b0;
    end else if (en) begin
      m_valid_r <= d.valid;
      q.valid   <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_x_r    <= d.x;
      m_prod_r <= prod_nxt;
      q.x      <= m_x_r;
      q.y      <= y_nxt;
    end
  end

endmodule

### sv/satellite_cnr_from_raw.sv
// Satellite carrier-to-noise converter: raw reading to CNR in 0.001 dB.
// Pipeline from input transfer to output valid: offset stage, 18 root
// cells, five two-stage Horner cells, output clamp register.
// Throughput one reading per cycle; the whole pipeline holds while the output
// register is full and not taken. Reset clears all stage valid flags.
// Depends on scnr_pkg, scnr_if, scnr_sqrt_cell, scnr_horner_cell.
module satellite_cnr_from_raw (
  input  logic              clk,
  input  logic              rst_n,
  scnr_in_if.sink           in_ch,
  scnr_out_if.source        out_ch
);
  import scnr_pkg::*;

  logic             en;
  logic [RAW_W-1:0] red;
  sqrt_stage_t      s0_r;
  sqrt_stage_t      sq [ROOT_W+1];
  hrn_stage_t       hs [HRN_N+1];

  logic                  out_valid_r;
  logic [OUT_W-1:0]      cnr_r;
  logic [OUT_W-1:0]      cnr_nxt;
  logic [Y_W-FRAC_W-2:0] y_int;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = out_valid_r;
  assign out_ch.cnr_millidb = cnr_r;

  assign red = (in_ch.raw_cn > CN_OFFSET) ? in_ch.raw_cn - CN_OFFSET : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (en) begin
      s0_r.valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.rad  <= {red, {(RAD_W-RAW_W){1'b0}}};
      s0_r.rem  <= '0;
      s0_r.root <= '0;
    end
  end

  assign sq[0] = s0_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    scnr_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (sq[i]),
      .q     (sq[i+1])
    );
  end

  assign hs[0].valid = sq[ROOT_W].valid;
  assign hs[0].x     = sq[ROOT_W].root;
  assign hs[0].y     = HRN_Y0;

  for (genvar j = 0; j < HRN_N; j++) begin : g_hrn
    scnr_horner_cell #(
      .K   (HRN_K[j]),
      .NEG (HRN_NEG[j])
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (hs[j]),
      .q     (hs[j+1])
    );
  end

  always_comb begin
    y_int = hs[HRN_N].y[Y_W-2:FRAC_W];
    if (hs[HRN_N].y[Y_W-1]) begin
      cnr_nxt = '0;
    end else if (y_int > (Y_W-FRAC_W-1)'(OUT_MAX)) begin
      cnr_nxt = OUT_MAX;
    end else begin
      cnr_nxt = OUT_W'(y_int);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= hs[HRN_N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnr_r <= cnr_nxt;
    end
  end

  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s0_r.valid)
    else $error("transfer did not enter the offset stage");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> cnr_r <= CNR_TOP)
    else $error("result above the value at zero reading");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s0_r.valid)
    else $error("stage valid left set by reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(hs[HRN_N].valid) && $stable(sq[ROOT_W].valid))
    else $error("pipeline advanced while held");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench for satellite_cnr_from_raw: predicts each CNR result from the raw reading
// and checks every output transfer in order. Depends on scnr_pkg, scnr_if and the RTL.
module tb;
  import scnr_pkg::*;

  localparam longint Q16         = 65536;
  localparam longint POLY_C5     = 16346;
  localparam longint POLY_C4     = 143410;
  localparam longint POLY_C3     = 502590;
  localparam longint POLY_C2     = 889770;
  localparam longint POLY_C1     = 895650;
  localparam longint POLY_C0     = 588570;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     LONG_HOLD   = 120;
  localparam int     DRAIN_WAIT  = 40;
  localparam int     RANDOM_N    = 800;
  localparam int     PRESSURE_N  = 80;
  localparam int     STEADY_N    = 150;

  localparam logic [RAW_W-1:0] EDGE_READINGS [22] = '{
    16'd0, 16'd1, 16'd2999, 16'd3000, 16'd3001, 16'd3004, 16'd3100, 16'd4024,
    16'd7096, 16'd10000, 16'd20000, 16'd37500, 16'd38000, 16'd38160, 16'd38400,
    16'd39000, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF
  };

  typedef struct {
    logic [RAW_W-1:0] raw;
    logic [OUT_W-1:0] cnr;
  } cnr_expect_t;

  logic clk;
  logic rst_n;

  scnr_in_if  in_ch();
  scnr_out_if out_ch();

  satellite_cnr_from_raw u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cnr_expect_t cnr_expected[$];
  int          cycle_count    = 0;
  int          mismatch_count = 0;
  int          readings_sent  = 0;
  int          cnr_checked    = 0;
  int          zero_results   = 0;
  int          input_stalls   = 0;
  bit          sender_idle    = 1'b0;
  bit          sink_idle      = 1'b0;
  bit          long_hold_req  = 1'b0;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned acc;
    longint unsigned cand;
    acc = 0;
    for (int b = 19; b >= 0; b--) begin
      cand = acc | (64'd1 << b);
      if (cand * cand <= v) acc = cand;
    end
    return acc;
  endfunction

  function automatic logic [OUT_W-1:0] cnr_of_raw(input logic [RAW_W-1:0] raw);
    longint red;
    longint x;
    longint y;
    longint whole;
    red = (raw > CN_OFFSET) ? longint'(raw) - longint'(CN_OFFSET) : 0;
    x = longint'(root_floor(longint'(red) << 20));
    y = POLY_C5 * x - POLY_C4 * Q16;
    y = ((x * y) >>> 16) + POLY_C3 * Q16;
    y = ((x * y) >>> 16) - POLY_C2 * Q16;
    y = ((x * y) >>> 16) + POLY_C1 * Q16;
    y = POLY_C0 * Q16 - ((x * y) >>> 16);
    if (y < 0) return '0;
    whole = y >>> 16;
    if (whole > longint'(OUT_MAX)) return OUT_MAX;
    return whole[OUT_W-1:0];
  endfunction

  function automatic logic [RAW_W-1:0] random_reading();
    case ($urandom_range(0, 9))
      0, 1:    return RAW_W'($urandom_range(0, 4000));
      2, 3:    return RAW_W'($urandom_range(3000, 12000));
      4, 5:    return RAW_W'($urandom_range(36000, 40000));
      default: return RAW_W'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, cnr_expected.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(1, 6) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin
    cnr_expect_t want;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (rst_n && in_ch.valid && !in_ch.ready) input_stalls++;
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (cnr_expected.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, actual cnr_millidb=%0d",
                   $time, out_ch.cnr_millidb);
          mismatch_count++;
        end else begin
          want = cnr_expected.pop_front();
          cnr_checked++;
          if (out_ch.cnr_millidb !== want.cnr) begin
            $display("%0t: cnr_millidb for raw_cn=%0d: expected %0d, actual %0d",
                     $time, want.raw, want.cnr, out_ch.cnr_millidb);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic send_reading(input logic [RAW_W-1:0] raw);
    cnr_expect_t item;
    int          gap;
    @(negedge clk);
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      gap          = $urandom_range(1, 6);
      in_ch.valid  = 1'b0;
      in_ch.raw_cn = RAW_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.raw_cn = raw;
    do @(posedge clk); while (!in_ch.ready);
    item.raw = raw;
    item.cnr = cnr_of_raw(raw);
    if (item.cnr == '0) zero_results++;
    cnr_expected.push_back(item);
    readings_sent++;
  endtask

  task automatic test_edge_readings();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    foreach (EDGE_READINGS[i]) send_reading(EDGE_READINGS[i]);
  endtask

  task automatic test_random_readings();
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    repeat (RANDOM_N) send_reading(random_reading());
  endtask

  task automatic test_output_backpressure();
    sender_idle   = 1'b0;
    sink_idle     = 1'b0;
    long_hold_req = 1'b1;
    repeat (PRESSURE_N) send_reading(random_reading());
  endtask

  task automatic test_steady_stream();
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    repeat (STEADY_N) send_reading(random_reading());
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.raw_cn = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_readings();
    test_random_readings();
    test_output_backpressure();
    test_steady_stream();

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (cnr_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Converted %0d readings, checked %0d results, %0d of them clamped to zero.",
             readings_sent, cnr_checked, zero_results);
    $display("Input stalled for %0d cycles under output backpressure; %0d mismatches.",
             input_stalls, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
sv/scnr_pkg.sv
sv/scnr_if.sv
sv/scnr_sqrt_cell.sv
sv/scnr_horner_cell.sv
sv/satellite_cnr_from_raw.sv
dv/tb.sv
